// ----- rtl/core/ndrl_pkg.sv -----
// Shared constants, action codes and the query token type for the display rectangle lookup.
`timescale 1ns / 1ps
`default_nettype none

package ndrl_pkg;

   localparam int MAX_DISPLAYS = 8;
   localparam int IDX_W        = 3;
   localparam int COORD_W      = 32;
   localparam int GAP_W        = 33;

   localparam logic [1:0] ACT_WRITE   = 2'd0;
   localparam logic [1:0] ACT_POINT   = 2'd1;
   localparam logic [1:0] ACT_PRIMARY = 2'd2;

   // Query token that walks the cell chain, carrying the best entry seen so far.
   typedef struct packed {
      logic             valid;
      logic             pmode;
      logic             found;
      logic [IDX_W-1:0] idx;
      logic [GAP_W-1:0] gap;
   } tok_type;

endpackage

`default_nettype wire

// ----- rtl/core/nearest_display_rect_lookup.sv -----
// Top level of the nearest display rectangle lookup: handshake, sequencer and cell chain.
`timescale 1ns / 1ps
`default_nettype none

// This block holds a table of MAX_DISPLAYS display rectangles, one per cell of a chain,
// each with a present and a primary bit. A write transaction loads one slot in the cycle
// it is accepted and returns nothing, as does the unused action code. A point query or a
// primary query latches the point, lets every cell register its Chebyshev gap to that
// point, then sends a token down the chain one cell per cycle; each cell replaces the
// token's best entry when it wins (first primary entry, or strictly smaller gap, so the
// earliest slot wins ties and containment is simply gap zero). The token passes every cell
// of the chain before its result is loaded into the response register, and the next
// transaction is accepted once that load has taken place. The response register is
// separate, so a new transaction is taken while an earlier response still waits for
// rsp_ready. With nothing qualifying, found, display_index, inside_res and distance are
// all zero.
module nearest_display_rect_lookup import ndrl_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_action,
   input  logic [IDX_W-1:0]          req_entry_index,
   input  logic                      req_entry_present,
   input  logic                      req_entry_primary,
   input  logic signed [COORD_W-1:0] req_rect_left,
   input  logic signed [COORD_W-1:0] req_rect_top,
   input  logic signed [COORD_W-1:0] req_rect_right,
   input  logic signed [COORD_W-1:0] req_rect_bottom,
   input  logic signed [COORD_W-1:0] req_point_x,
   input  logic signed [COORD_W-1:0] req_point_y,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_found,
   output logic [IDX_W-1:0]          rsp_display_index,
   output logic                      rsp_inside_res,
   output logic [GAP_W-1:0]          rsp_distance
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_GAP  = 2'd1;
   localparam logic [1:0] ST_RUN  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]                state_ff;
   logic [1:0]                state_in;
   logic                      req_accept;
   logic                      is_query;
   logic                      wr_accept;
   logic signed [COORD_W-1:0] point_x_ff;
   logic signed [COORD_W-1:0] point_y_ff;
   logic                      pmode_ff;
   tok_type                   tok0_ff;
   tok_type                   tok0_in;
   tok_type                   pend_ff;
   tok_type                   tok_link [0:MAX_DISPLAYS];
   logic [MAX_DISPLAYS-1:0]   tok_valid_vec;
   logic                      rsp_free;
   logic                      rsp_load;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic                      rsp_found_ff;
   logic [IDX_W-1:0]          rsp_idx_ff;
   logic                      rsp_inside_ff;
   logic [GAP_W-1:0]          rsp_dist_ff;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign is_query   = (req_action == ACT_POINT) || (req_action == ACT_PRIMARY);
   assign wr_accept  = req_accept && (req_action == ACT_WRITE);
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_load   = (state_ff == ST_DONE) && rsp_free;

   // Sequencer: latch point, wait in the gap state for the cell gaps, run the chain, hand off.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && is_query) begin
               state_in = ST_GAP;
            end
         end
         ST_GAP: begin
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (tok_link[MAX_DISPLAYS].valid) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && is_query) begin
         point_x_ff <= req_point_x;
         point_y_ff <= req_point_y;
         pmode_ff   <= (req_action == ACT_PRIMARY);
      end
   end

   // The token enters the chain once every cell holds the gap for the new point.
   always_comb begin
      tok0_in       = '0;
      tok0_in.valid = (state_ff == ST_GAP);
      tok0_in.pmode = pmode_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok0_ff <= '0;
      end else begin
         tok0_ff <= tok0_in;
      end
   end

   assign tok_link[0] = tok0_ff;

   for (genvar i = 0; i < MAX_DISPLAYS; i++) begin : g_cell
      logic cell_wr;
      assign cell_wr = wr_accept && (int'(req_entry_index) == i);

      ndrl_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_id    (IDX_W'(i)),
         .wr_en      (cell_wr),
         .wr_present (req_entry_present),
         .wr_primary (req_entry_primary),
         .wr_left    (req_rect_left),
         .wr_top     (req_rect_top),
         .wr_right   (req_rect_right),
         .wr_bottom  (req_rect_bottom),
         .point_x    (point_x_ff),
         .point_y    (point_y_ff),
         .tok_in     (tok_link[i]),
         .tok_out    (tok_link[i+1])
      );

      assign tok_valid_vec[i] = tok_link[i+1].valid;
   end

   // The finished token waits here until the response register is free.
   always_ff @(posedge clock) begin
      if ((state_ff == ST_RUN) && tok_link[MAX_DISPLAYS].valid) begin
         pend_ff <= tok_link[MAX_DISPLAYS];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_found_ff  <= pend_ff.found;
         rsp_idx_ff    <= pend_ff.idx;
         rsp_inside_ff <= pend_ff.found && (pend_ff.gap == '0);
         rsp_dist_ff   <= pend_ff.gap;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_display_index = rsp_idx_ff;
   assign rsp_inside_res    = rsp_inside_ff;
   assign rsp_distance      = rsp_dist_ff;

   a_single_token: assert property (@(posedge clock) disable iff (reset)
      $countones({tok_valid_vec, tok0_ff.valid}) <= 1)
      else $error("more than one query token in the cell chain");

   a_token_end_in_run: assert property (@(posedge clock) disable iff (reset)
      tok_link[MAX_DISPLAYS].valid |-> (state_ff == ST_RUN))
      else $error("token left the chain outside the run state");

   a_token_advances: assert property (@(posedge clock) disable iff (reset)
      tok0_ff.valid |=> tok_link[1].valid)
      else $error("query token did not advance into the first cell");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |->
         ((rsp_idx_ff == '0) && (rsp_dist_ff == '0) && !rsp_inside_ff))
      else $error("empty response carries nonzero fields");

   a_inside_zero_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_inside_ff) |-> (rsp_dist_ff == '0))
      else $error("inside response with nonzero distance");

endmodule

`default_nettype wire

// ----- rtl/core/ndrl_cell.sv -----
// One table slot of the lookup chain: stored rectangle, gap unit and token stage.
`timescale 1ns / 1ps
`default_nettype none

module ndrl_cell import ndrl_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [IDX_W-1:0]          cell_id,
   input  logic                      wr_en,
   input  logic                      wr_present,
   input  logic                      wr_primary,
   input  logic signed [COORD_W-1:0] wr_left,
   input  logic signed [COORD_W-1:0] wr_top,
   input  logic signed [COORD_W-1:0] wr_right,
   input  logic signed [COORD_W-1:0] wr_bottom,
   input  logic signed [COORD_W-1:0] point_x,
   input  logic signed [COORD_W-1:0] point_y,
   input  tok_type                   tok_in,
   output tok_type                   tok_out
);

   logic signed [COORD_W-1:0] left_ff;
   logic signed [COORD_W-1:0] top_ff;
   logic signed [COORD_W:0]   last_x_ff;
   logic signed [COORD_W:0]   last_y_ff;
   logic signed [COORD_W:0]   last_x_in;
   logic signed [COORD_W:0]   last_y_in;
   logic                      present_ff;
   logic                      primary_ff;
   logic [GAP_W-1:0]          dx;
   logic [GAP_W-1:0]          dy;
   logic [GAP_W-1:0]          gap_in;
   logic [GAP_W-1:0]          gap_ff;
   logic                      take;
   tok_type                   tok_in_next;
   tok_type                   tok_ff;

   // Distance of v outside the span from lo up to last, zero when within it.
   function automatic logic [GAP_W-1:0] span_gap(input logic signed [COORD_W-1:0] lo,
                                                  input logic signed [COORD_W:0]   last,
                                                  input logic signed [COORD_W-1:0] v);
      logic signed [COORD_W+1:0] lo_e;
      logic signed [COORD_W+1:0] last_e;
      logic signed [COORD_W+1:0] v_e;
      logic signed [COORD_W+1:0] d_lo;
      logic signed [COORD_W+1:0] d_hi;
      logic [GAP_W-1:0]          res;
      lo_e   = {{2{lo[COORD_W-1]}}, lo};
      last_e = {last[COORD_W], last};
      v_e    = {{2{v[COORD_W-1]}}, v};
      d_lo   = lo_e - v_e;
      d_hi   = v_e - last_e;
      if (v_e < lo_e) begin
         res = d_lo[GAP_W-1:0];
      end else if (v_e > last_e) begin
         res = d_hi[GAP_W-1:0];
      end else begin
         res = '0;
      end
      return res;
   endfunction

   // The exclusive right and bottom edges are kept as their last covered column and row.
   assign last_x_in = {wr_right[COORD_W-1], wr_right} - (COORD_W+1)'(1);
   assign last_y_in = {wr_bottom[COORD_W-1], wr_bottom} - (COORD_W+1)'(1);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         left_ff   <= wr_left;
         top_ff    <= wr_top;
         last_x_ff <= last_x_in;
         last_y_ff <= last_y_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= 1'b0;
         primary_ff <= 1'b0;
      end else if (wr_en) begin
         present_ff <= wr_present;
         primary_ff <= wr_primary;
      end
   end

   // The gap is registered every cycle from the held query point.
   always_comb begin
      dx     = span_gap(left_ff, last_x_ff, point_x);
      dy     = span_gap(top_ff, last_y_ff, point_y);
      gap_in = (dx > dy) ? dx : dy;
   end

   always_ff @(posedge clock) begin
      gap_ff <= gap_in;
   end

   always_comb begin
      if (tok_in.pmode) begin
         take = tok_in.valid && present_ff && primary_ff && !tok_in.found;
      end else begin
         take = tok_in.valid && present_ff && (!tok_in.found || (gap_ff < tok_in.gap));
      end
      tok_in_next = tok_in;
      if (take) begin
         tok_in_next.found = 1'b1;
         tok_in_next.idx   = cell_id;
         tok_in_next.gap   = gap_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;

endmodule

`default_nettype wire
